@@ design/aal_pkg.sv @@
// ----------------------------------------------------------------------------
// aal_pkg: shared types for the area locator
// Command codes, the queued word passed from front to back, entry layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package aal_pkg;

	localparam int COORD_W   = 20;
	localparam int ID_W      = 16;
	localparam int RANK_W    = 16;
	localparam int VOL_W     = 60;
	localparam int SLOT_W    = 6;
	localparam int NIDX_W    = 3;
	localparam int MAX_SLOTS = 2 ** SLOT_W;

	typedef enum logic [1:0] {
		CMD_LOWER = 2'd0,
		CMD_UPPER = 2'd1,
		CMD_NBR   = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                       cmd;
		logic                       reject;
		logic [SLOT_W-1:0]          slot;
		logic [ID_W-1:0]            area_id;
		logic                       present;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [COORD_W-1:0]  z;
		logic signed [RANK_W-1:0]   rank;
		logic [NIDX_W-1:0]          nidx;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]            id;
		logic signed [RANK_W-1:0]   rank;
		logic signed [COORD_W-1:0]  lo_x;
		logic signed [COORD_W-1:0]  lo_y;
		logic signed [COORD_W-1:0]  lo_z;
	} ent_lo_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]  hi_x;
		logic signed [COORD_W-1:0]  hi_y;
		logic signed [COORD_W-1:0]  hi_z;
		logic [VOL_W-1:0]           vol;
	} ent_hi_t;

	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
	} nbr_t;

endpackage

`default_nettype wire

@@ design/aal_ram.sv @@
// ----------------------------------------------------------------------------
// aal_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ design/aal_front.sv @@
// ----------------------------------------------------------------------------
// aal_front: input acceptance and classification
// Range-checks each word and holds it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module aal_front
	import aal_pkg::*;
#(
	parameter int AREA_COUNT     = 64,
	parameter int NEIGHBOR_COUNT = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                cmd,
	input  wire logic [SLOT_W-1:0]         slot,
	input  wire logic [ID_W-1:0]           area_id,
	input  wire logic                      present,
	input  wire logic signed [COORD_W-1:0] x,
	input  wire logic signed [COORD_W-1:0] y,
	input  wire logic signed [COORD_W-1:0] z,
	input  wire logic signed [RANK_W-1:0]  priority_req,
	input  wire logic [NIDX_W-1:0]         neighbor_index,
	input  wire logic                      q_pop,
	output logic                           q_empty,
	output item_t                          q_item
);

	localparam int SLOTS = (AREA_COUNT < MAX_SLOTS) ? AREA_COUNT : MAX_SLOTS;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       slot_ok;
	logic       nidx_ok;
	item_t      item_in;

	assign slot_ok = 32'(slot) < SLOTS;
	assign nidx_ok = 32'(neighbor_index) < NEIGHBOR_COUNT;

	always_comb begin
		item_in.cmd     = cmd_t'(cmd);
		item_in.slot    = slot;
		item_in.area_id = area_id;
		item_in.present = present;
		item_in.x       = x;
		item_in.y       = y;
		item_in.z       = z;
		item_in.rank    = priority_req;
		item_in.nidx    = neighbor_index;
		unique case (cmd_t'(cmd)) inside
			CMD_LOWER, CMD_UPPER: item_in.reject = !slot_ok;
			CMD_NBR:              item_in.reject = !(slot_ok && nidx_ok);
			default:              item_in.reject = 1'b0;
		endcase
	end

	assign in_stall = cnt_q[1];
	assign push     = in_valid && !in_stall;
	assign q_empty  = (cnt_q == 2'd0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/aal_back.sv @@
// ----------------------------------------------------------------------------
// aal_back: command execution engine
// Table writes, volume computation and the query search, plus result register.
// ----------------------------------------------------------------------------
`default_nettype none

module aal_back
	import aal_pkg::*;
#(
	parameter int AREA_COUNT     = 64,
	parameter int NEIGHBOR_COUNT = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire item_t          q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic                accepted,
	output logic                found,
	output logic [ID_W-1:0]     result_id
);

	localparam int SLOTS    = (AREA_COUNT < MAX_SLOTS) ? AREA_COUNT : MAX_SLOTS;
	localparam int IW       = $clog2(SLOTS);
	localparam int NB_DEPTH = SLOTS * NEIGHBOR_COUNT;
	localparam int NAW      = $clog2(NB_DEPTH);
	localparam int KW       = (NEIGHBOR_COUNT > 1) ? $clog2(NEIGHBOR_COUNT) : 1;

	typedef enum logic [11:0] {
		S_CLR     = 12'b0000_0000_0001,
		S_IDLE    = 12'b0000_0000_0010,
		S_UP_CHK  = 12'b0000_0000_0100,
		S_UP_M1   = 12'b0000_0000_1000,
		S_UP_M2   = 12'b0000_0001_0000,
		S_UP_WR   = 12'b0000_0010_0000,
		S_SCAN    = 12'b0000_0100_0000,
		S_NB_RD   = 12'b0000_1000_0000,
		S_NB_CHK  = 12'b0001_0000_0000,
		S_NB_NEXT = 12'b0010_0000_0000,
		S_DONE    = 12'b0100_0000_0000,
		S_SPARE   = 12'b1000_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		M_CUR  = 2'd0,
		M_NBR  = 2'd1,
		M_FULL = 2'd2
	} mode_t;

	state_t                st_q;
	mode_t                 mode_q;
	item_t                 item_q;
	logic [SLOTS-1:0]      valid_q;
	logic [NAW-1:0]        clr_q;
	logic [IW-1:0]         scan_q;
	logic                  issuing_q;
	logic                  ev_vld_s1;
	logic [IW-1:0]         ev_idx_s1;
	logic [IW-1:0]         cur_slot_q;
	logic [KW-1:0]         k_q;
	logic [ID_W-1:0]       target_q;
	logic                  acc_q;
	logic                  best_found_q;
	logic signed [RANK_W-1:0] best_rank_q;
	logic [VOL_W-1:0]      best_vol_q;
	logic [ID_W-1:0]       best_id_q;
	logic [COORD_W-1:0]    ext_x_s1;
	logic [COORD_W-1:0]    ext_y_s1;
	logic [COORD_W-1:0]    ext_z_s1;
	logic [COORD_W-1:0]    ext_z_s2;
	logic [2*COORD_W-1:0]  prod_s2;
	logic [VOL_W-1:0]      vol_s3;
	logic                  out_valid_q;
	logic                  accepted_q;
	logic                  found_q;
	logic [ID_W-1:0]       result_id_q;

	ent_lo_t               lo_rd;
	ent_hi_t               hi_rd;
	nbr_t                  nb_rd;
	ent_lo_t               lo_wr;
	ent_hi_t               hi_wr;
	nbr_t                  nb_wr;
	logic [IW-1:0]         ent_raddr;
	logic [IW-1:0]         head_slot;
	logic [IW-1:0]         item_slot;
	logic                  lo_we;
	logic                  nb_we;
	logic [NAW-1:0]        nb_waddr;
	logic [NAW-1:0]        nb_raddr;
	logic                  dispatch;
	logic                  out_free;
	logic                  ev_live;
	logic                  ev_valid;
	logic                  id_hit;
	logic                  scan_hit;
	logic                  holds;
	logic                  beats;
	logic                  upper_ok;
	logic [COORD_W:0]      dx;
	logic [COORD_W:0]      dy;
	logic [COORD_W:0]      dz;

	assign head_slot = IW'(q_item.slot);
	assign item_slot = IW'(item_q.slot);
	assign dispatch  = (st_q == S_IDLE) && !q_empty;
	assign q_pop     = dispatch;
	assign out_free  = !out_valid_q || !out_stall;

	// ---- entry tables ----
	assign ent_raddr = (st_q == S_SCAN) ? scan_q : head_slot;
	assign lo_we     = dispatch && (q_item.cmd == CMD_LOWER) && !q_item.reject;

	always_comb begin
		lo_wr.id   = q_item.area_id;
		lo_wr.rank = q_item.rank;
		lo_wr.lo_x = q_item.x;
		lo_wr.lo_y = q_item.y;
		lo_wr.lo_z = q_item.z;
		hi_wr.hi_x = item_q.x;
		hi_wr.hi_y = item_q.y;
		hi_wr.hi_z = item_q.z;
		hi_wr.vol  = vol_s3;
	end

	aal_ram #(.WIDTH($bits(ent_lo_t)), .DEPTH(SLOTS)) u_lo_ram (
		.clk   (clk),
		.we    (lo_we),
		.waddr (head_slot),
		.wdata (lo_wr),
		.raddr (ent_raddr),
		.rdata (lo_rd)
	);

	aal_ram #(.WIDTH($bits(ent_hi_t)), .DEPTH(SLOTS)) u_hi_ram (
		.clk   (clk),
		.we    (st_q == S_UP_WR),
		.waddr (item_slot),
		.wdata (hi_wr),
		.raddr (ent_raddr),
		.rdata (hi_rd)
	);

	// ---- neighbor table, swept to zero after reset ----
	always_comb begin
		if (st_q == S_CLR) begin
			nb_we       = 1'b1;
			nb_waddr    = clr_q;
			nb_wr.valid = 1'b0;
			nb_wr.id    = '0;
		end else begin
			nb_we       = dispatch && (q_item.cmd == CMD_NBR) && !q_item.reject;
			nb_waddr    = NAW'(NAW'(head_slot) * NAW'(NEIGHBOR_COUNT)) + NAW'(q_item.nidx);
			nb_wr.valid = q_item.present;
			nb_wr.id    = q_item.area_id;
		end
	end

	assign nb_raddr = NAW'(NAW'(cur_slot_q) * NAW'(NEIGHBOR_COUNT)) + NAW'(k_q);

	aal_ram #(.WIDTH($bits(nbr_t)), .DEPTH(NB_DEPTH)) u_nb_ram (
		.clk   (clk),
		.we    (nb_we),
		.waddr (nb_waddr),
		.wdata (nb_wr),
		.raddr (nb_raddr),
		.rdata (nb_rd)
	);

	// ---- upper corner check and extents ----
	assign upper_ok = (item_q.x >= lo_rd.lo_x) && (item_q.y >= lo_rd.lo_y)
		&& (item_q.z >= lo_rd.lo_z);
	assign dx = (COORD_W+1)'(item_q.x) - (COORD_W+1)'(lo_rd.lo_x);
	assign dy = (COORD_W+1)'(item_q.y) - (COORD_W+1)'(lo_rd.lo_y);
	assign dz = (COORD_W+1)'(item_q.z) - (COORD_W+1)'(lo_rd.lo_z);

	// ---- scan evaluation of the entry read last cycle ----
	assign ev_live  = (st_q == S_SCAN) && ev_vld_s1;
	assign ev_valid = valid_q[ev_idx_s1];
	assign id_hit   = ev_valid && (lo_rd.id == target_q);
	assign scan_hit = ev_live && (mode_q != M_FULL) && id_hit;
	assign holds = (item_q.x >= lo_rd.lo_x) && (item_q.x <= hi_rd.hi_x)
		&& (item_q.y >= lo_rd.lo_y) && (item_q.y <= hi_rd.hi_y)
		&& (item_q.z >= lo_rd.lo_z) && (item_q.z <= hi_rd.hi_z);
	assign beats = !best_found_q || (lo_rd.rank > best_rank_q)
		|| ((lo_rd.rank == best_rank_q) && ((hi_rd.vol < best_vol_q)
		|| ((hi_rd.vol == best_vol_q) && (lo_rd.id < best_id_q))));

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		if (dispatch) begin
			item_q <= q_item;
		end
		ext_x_s1 <= dx[COORD_W-1:0];
		ext_y_s1 <= dy[COORD_W-1:0];
		ext_z_s1 <= dz[COORD_W-1:0];
		prod_s2  <= ext_x_s1 * ext_y_s1;
		ext_z_s2 <= ext_z_s1;
		vol_s3   <= prod_s2 * ext_z_s2;
		ev_idx_s1 <= scan_q;
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_CLR;
			mode_q       <= M_FULL;
			valid_q      <= '0;
			clr_q        <= '0;
			scan_q       <= '0;
			issuing_q    <= 1'b0;
			ev_vld_s1    <= 1'b0;
			cur_slot_q   <= '0;
			k_q          <= '0;
			target_q     <= '0;
			acc_q        <= 1'b0;
			best_found_q <= 1'b0;
			best_rank_q  <= '0;
			best_vol_q   <= '0;
			best_id_q    <= '0;
			out_valid_q  <= 1'b0;
			accepted_q   <= 1'b0;
			found_q      <= 1'b0;
			result_id_q  <= '0;
		end else begin
			ev_vld_s1 <= (st_q == S_SCAN) && issuing_q;
			if (out_valid_q && !out_stall && (st_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + NAW'(1);
					if (clr_q == NAW'(NB_DEPTH - 1)) begin
						st_q <= S_IDLE;
					end
				end

				S_IDLE: begin
					if (!q_empty) begin
						best_found_q <= 1'b0;
						if (q_item.reject) begin
							acc_q <= 1'b0;
							st_q  <= S_DONE;
						end else begin
							unique case (q_item.cmd)
								CMD_LOWER: begin
									valid_q[head_slot] <= 1'b0;
									acc_q              <= 1'b1;
									st_q               <= S_DONE;
								end
								CMD_UPPER: begin
									if (!q_item.present) begin
										valid_q[head_slot] <= 1'b0;
										acc_q              <= 1'b1;
										st_q               <= S_DONE;
									end else begin
										acc_q <= 1'b0;
										st_q  <= S_UP_CHK;
									end
								end
								CMD_NBR: begin
									acc_q <= 1'b1;
									st_q  <= S_DONE;
								end
								CMD_QUERY: begin
									acc_q     <= 1'b0;
									mode_q    <= q_item.present ? M_CUR : M_FULL;
									target_q  <= q_item.area_id;
									scan_q    <= '0;
									issuing_q <= 1'b1;
									st_q      <= S_SCAN;
								end
							endcase
						end
					end
				end

				S_UP_CHK: begin
					if (upper_ok) begin
						st_q <= S_UP_M1;
					end else begin
						valid_q[item_slot] <= 1'b0;
						st_q               <= S_DONE;
					end
				end

				S_UP_M1: begin
					st_q <= S_UP_M2;
				end

				S_UP_M2: begin
					st_q <= S_UP_WR;
				end

				S_UP_WR: begin
					valid_q[item_slot] <= 1'b1;
					acc_q              <= 1'b1;
					st_q               <= S_DONE;
				end

				S_SCAN: begin
					// advance the read pointer; stop issuing after the last entry or, outside a full scan, on an id match
					if (issuing_q) begin
						scan_q <= scan_q + IW'(1);
						if ((scan_q == IW'(SLOTS - 1)) || scan_hit) begin
							issuing_q <= 1'b0;
						end
					end
					if (ev_live) begin
						unique case (mode_q)
							M_CUR: begin
								if (id_hit) begin
									if (holds) begin
										best_found_q <= 1'b1;
										best_id_q    <= lo_rd.id;
										st_q         <= S_DONE;
									end else begin
										cur_slot_q <= ev_idx_s1;
										k_q        <= '0;
										st_q       <= S_NB_RD;
									end
								end
							end
							M_NBR: begin
								if (id_hit) begin
									if (holds && beats) begin
										best_found_q <= 1'b1;
										best_rank_q  <= lo_rd.rank;
										best_vol_q   <= hi_rd.vol;
										best_id_q    <= lo_rd.id;
									end
									st_q <= S_NB_NEXT;
								end
							end
							default: begin
								if (ev_valid && holds && beats) begin
									best_found_q <= 1'b1;
									best_rank_q  <= lo_rd.rank;
									best_vol_q   <= hi_rd.vol;
									best_id_q    <= lo_rd.id;
								end
							end
						endcase
					end else if (!issuing_q && !ev_vld_s1) begin
						// pass over the whole table finished without an early exit
						unique case (mode_q)
							M_CUR: begin
								mode_q    <= M_FULL;
								scan_q    <= '0;
								issuing_q <= 1'b1;
							end
							M_NBR: begin
								st_q <= S_NB_NEXT;
							end
							default: begin
								st_q <= S_DONE;
							end
						endcase
					end
				end

				S_NB_RD: begin
					st_q <= S_NB_CHK;
				end

				S_NB_CHK: begin
					if (nb_rd.valid) begin
						mode_q    <= M_NBR;
						target_q  <= nb_rd.id;
						scan_q    <= '0;
						issuing_q <= 1'b1;
						st_q      <= S_SCAN;
					end else begin
						st_q <= S_NB_NEXT;
					end
				end

				S_NB_NEXT: begin
					if (32'(k_q) == NEIGHBOR_COUNT - 1) begin
						if (best_found_q) begin
							st_q <= S_DONE;
						end else begin
							mode_q    <= M_FULL;
							scan_q    <= '0;
							issuing_q <= 1'b1;
							st_q      <= S_SCAN;
						end
					end else begin
						k_q  <= k_q + KW'(1);
						st_q <= S_NB_RD;
					end
				end

				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						accepted_q  <= acc_q;
						found_q     <= best_found_q;
						result_id_q <= best_found_q ? best_id_q : '0;
						st_q        <= S_IDLE;
					end
				end

				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;
	assign found     = found_q;
	assign result_id = result_id_q;

endmodule

`default_nettype wire

@@ design/priority_aabb_area_locator_core.sv @@
// ----------------------------------------------------------------------------
// priority_aabb_area_locator_core: point-in-box area locator with priorities
// An upper corner with volume passes the corner check and the volume multiply
// states (S_UP_M1, S_UP_M2) before its table write. A query scans the
// single-read-port entry table one entry per cycle. One word is processed at a time.
// After reset the neighbor table, slots * NEIGHBOR_COUNT entries (512 by default),
// is swept to zero; input words queue up but are not executed meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_aabb_area_locator_core
	import aal_pkg::*;
#(
	parameter int AREA_COUNT     = 64,
	parameter int NEIGHBOR_COUNT = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// input channel
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                cmd,
	input  wire logic [SLOT_W-1:0]         slot,
	input  wire logic [ID_W-1:0]           area_id,
	input  wire logic                      present,
	input  wire logic signed [COORD_W-1:0] x,
	input  wire logic signed [COORD_W-1:0] y,
	input  wire logic signed [COORD_W-1:0] z,
	input  wire logic signed [RANK_W-1:0]  priority_req,
	input  wire logic [NIDX_W-1:0]         neighbor_index,
	// result channel
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           accepted,
	output logic                           found,
	output logic [ID_W-1:0]                result_id
);

	// Front: accept each word, range-check the slot and neighbor index, and
	// hold it in a two-entry queue so the input side can pass up to two words
	// ahead while the back end is busy with a long query.
	logic  q_pop;
	logic  q_empty;
	item_t q_item;

	aal_front #(
		.AREA_COUNT     (AREA_COUNT),
		.NEIGHBOR_COUNT (NEIGHBOR_COUNT)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.slot           (slot),
		.area_id        (area_id),
		.present        (present),
		.x              (x),
		.y              (y),
		.z              (z),
		.priority_req   (priority_req),
		.neighbor_index (neighbor_index),
		.q_pop          (q_pop),
		.q_empty        (q_empty),
		.q_item         (q_item)
	);

	// Back: execute one word at a time. Queries search the current area by id
	// when present is set, then each valid neighbor by id, then fall back to a full scan,
	// keeping the best candidate (priority, then volume, then id). The result
	// lands in an output register that holds while stalled.
	aal_back #(
		.AREA_COUNT     (AREA_COUNT),
		.NEIGHBOR_COUNT (NEIGHBOR_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.accepted  (accepted),
		.found     (found),
		.result_id (result_id)
	);

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for priority_aabb_area_locator_core
// Loads boxes, rejects bad upper corners, wires neighbor lists and resolves
// query points; every result word is checked against an in-bench predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import aal_pkg::*;

	localparam int SLOTS     = 64;
	localparam int NBRS      = 8;
	localparam int ITEM_GOAL = 700;
	localparam int CYC_LIMIT = 3000000;
	localparam int COORD_MAX = 524287;
	localparam int COORD_MIN = -524288;

	typedef struct {
		cmd_t                      cmd;
		logic [SLOT_W-1:0]         slot;
		logic [ID_W-1:0]           id;
		logic                      present;
		logic signed [COORD_W-1:0] x, y, z;
		logic signed [RANK_W-1:0]  prio;
		logic [NIDX_W-1:0]         nidx;
		bit                        hold;   // wait for all results before sending
	} word_t;

	typedef struct {
		logic            acc;
		logic            fnd;
		logic [ID_W-1:0] rid;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = '0;
	logic [SLOT_W-1:0] slot = '0;
	logic [ID_W-1:0] area_id = '0;
	logic present = 1'b0;
	logic signed [COORD_W-1:0] x = '0, y = '0, z = '0;
	logic signed [RANK_W-1:0] priority_req = '0;
	logic [NIDX_W-1:0] neighbor_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic accepted, found;
	logic [ID_W-1:0] result_id;

	priority_aabb_area_locator_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .slot(slot), .area_id(area_id), .present(present),
		.x(x), .y(y), .z(z), .priority_req(priority_req),
		.neighbor_index(neighbor_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.accepted(accepted), .found(found), .result_id(result_id)
	);

	// Shadow copy of the area table.
	bit              box_live [SLOTS];
	logic [ID_W-1:0] box_id   [SLOTS];
	int              box_rank [SLOTS];
	int              box_lo   [SLOTS][3];
	int              box_hi   [SLOTS][3];
	longint unsigned box_vol  [SLOTS];
	bit              nbr_live [SLOTS][NBRS];
	logic [ID_W-1:0] nbr_id   [SLOTS][NBRS];

	// Generator-side memory of lower corners, so upper writes hit written slots.
	bit gen_lo_set [SLOTS];
	int gen_lo     [SLOTS][3];

	word_t   send_q[$];
	answer_t answer_q[$];
	word_t   drv_word;
	int      n_sent, n_recv, n_err, cycles;
	int      n_found, n_missed;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic bit box_holds(int e, int p[3]);
		for (int a = 0; a < 3; a++)
			if (p[a] < box_lo[e][a] || p[a] > box_hi[e][a])
				return 0;
		return 1;
	endfunction

	function automatic bit outranks(int cand, int best);
		if (best < 0)
			return 1;
		if (box_rank[cand] != box_rank[best])
			return box_rank[cand] > box_rank[best];
		if (box_vol[cand] != box_vol[best])
			return box_vol[cand] < box_vol[best];
		return box_id[cand] < box_id[best];
	endfunction

	function automatic int find_slot(logic [ID_W-1:0] id);
		for (int i = 0; i < SLOTS; i++)
			if (box_live[i] && box_id[i] == id)
				return i;
		return -1;
	endfunction

	// Apply one word to the shadow table and return the answer it produces.
	function automatic answer_t resolve_word(word_t w);
		answer_t r;
		int p[3];
		int s, best, home, e;
		bit fits;
		longint unsigned vol;
		r = '{acc: 1'b0, fnd: 1'b0, rid: '0};
		p[0] = int'(w.x);
		p[1] = int'(w.y);
		p[2] = int'(w.z);
		s = int'(w.slot);
		best = -1;
		case (w.cmd)
			CMD_LOWER: begin
				box_id[s] = w.id;
				box_rank[s] = int'(w.prio);
				for (int a = 0; a < 3; a++)
					box_lo[s][a] = p[a];
				box_live[s] = 0;
				r.acc = 1'b1;
			end
			CMD_UPPER: begin
				if (!w.present) begin
					box_live[s] = 0;
					r.acc = 1'b1;
				end else begin
					fits = 1;
					for (int a = 0; a < 3; a++)
						if (p[a] < box_lo[s][a])
							fits = 0;
					if (fits) begin
						vol = 1;
						for (int a = 0; a < 3; a++) begin
							box_hi[s][a] = p[a];
							vol = vol * longint'(p[a] - box_lo[s][a]);
						end
						box_vol[s] = vol;
						box_live[s] = 1;
						r.acc = 1'b1;
					end else begin
						box_live[s] = 0;
					end
				end
			end
			CMD_NBR: begin
				nbr_live[s][w.nidx] = w.present;
				nbr_id[s][w.nidx] = w.id;
				r.acc = 1'b1;
			end
			default: begin
				home = w.present ? find_slot(w.id) : -1;
				if (home >= 0) begin
					if (box_holds(home, p))
						best = home;
					else
						for (int k = 0; k < NBRS; k++) begin
							if (!nbr_live[home][k])
								continue;
							e = find_slot(nbr_id[home][k]);
							if (e >= 0 && box_holds(e, p) && outranks(e, best))
								best = e;
						end
				end
				if (best < 0)
					for (int i = 0; i < SLOTS; i++)
						if (box_live[i] && box_holds(i, p) && outranks(i, best))
							best = i;
				if (best >= 0) begin
					r.fnd = 1'b1;
					r.rid = box_id[best];
				end
			end
		endcase
		return r;
	endfunction

	task automatic push_word(cmd_t c, int s, int id, bit pr, int px, int py, int pz,
			int prio, int ni, bit hold);
		word_t w;
		w.cmd = c;
		w.slot = s[SLOT_W-1:0];
		w.id = id[ID_W-1:0];
		w.present = pr;
		w.x = px[COORD_W-1:0];
		w.y = py[COORD_W-1:0];
		w.z = pz[COORD_W-1:0];
		w.prio = prio[RANK_W-1:0];
		w.nidx = ni[NIDX_W-1:0];
		w.hold = hold;
		if (c == CMD_LOWER) begin
			gen_lo_set[s] = 1;
			gen_lo[s] = '{px, py, pz};
		end
		send_q.insert(send_q.size(), w);
	endtask

	function automatic int pick_coord();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, 3000) - 1500;
		return int'($urandom_range(0, 1048575)) + COORD_MIN;
	endfunction

	function automatic int pick_id();
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(1, 40);
		return $urandom_range(0, 65535);
	endfunction

	function automatic int pick_rank();
		if ($urandom_range(0, 99) < 75)
			return $urandom_range(0, 6) - 3;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int clamp_up(int v);
		return (v > COORD_MAX) ? COORD_MAX : v;
	endfunction

	// Random lower + upper pair building a box; a few go bad on purpose.
	task automatic push_box(int s);
		int lx, ly, lz, mode;
		lx = pick_coord();
		ly = pick_coord();
		lz = pick_coord();
		mode = $urandom_range(0, 99);
		push_word(CMD_LOWER, s, pick_id(), 1, lx, ly, lz, pick_rank(), 0, 0);
		if (mode < 10)
			push_word(CMD_UPPER, s, 0, 1, lx - 1 + $urandom_range(0, 1) * 2,
				ly - $urandom_range(0, 2), lz - $urandom_range(1, 3), 0, 0, 0);
		else
			push_word(CMD_UPPER, s, 0, 1, clamp_up(lx + $urandom_range(0, 1400)),
				clamp_up(ly + $urandom_range(0, 1400)), clamp_up(lz + $urandom_range(0, 1400)),
				0, 0, 0);
	endtask

	task automatic build_stimulus();
		int r, s;
		// Directed: huge box at full extremes, small boxes, ties and duplicates.
		push_word(CMD_LOWER, 0, 65535, 1, COORD_MIN, COORD_MIN, COORD_MIN, -32768, 0, 0);
		push_word(CMD_UPPER, 0, 0, 1, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0);
		push_word(CMD_LOWER, 1, 0, 1, 0, 0, 0, 32767, 0, 0);
		push_word(CMD_UPPER, 1, 0, 1, 100, 100, 100, 0, 0, 0);
		push_word(CMD_LOWER, 2, 7, 1, 50, 50, 50, 32767, 0, 0);
		push_word(CMD_UPPER, 2, 0, 1, 150, 150, 150, 0, 0, 0);   // same rank and volume as slot 1
		push_word(CMD_LOWER, 3, 7, 1, 200, 200, 200, 5, 0, 0);   // duplicate id
		push_word(CMD_UPPER, 3, 0, 1, 300, 300, 199, 0, 0, 0);   // upper below lower: reject
		push_word(CMD_UPPER, 3, 0, 1, 300, 300, 300, 0, 0, 0);
		push_word(CMD_NBR, 3, 0, 1, 0, 0, 0, 0, 7, 0);
		push_word(CMD_NBR, 3, 65535, 1, 0, 0, 0, 0, 0, 0);
		push_word(CMD_NBR, 3, 7, 0, 0, 0, 0, 0, 3, 0);
		push_word(CMD_QUERY, 0, 7, 1, 60, 60, 60, 0, 0, 1);      // current holds point
		push_word(CMD_QUERY, 0, 7, 1, 10, 10, 10, 0, 0, 0);      // current misses point
		push_word(CMD_QUERY, 0, 7, 1, 300, 300, 300, 0, 0, 0);
		push_word(CMD_QUERY, 0, 999, 1, 100, 100, 100, 0, 0, 0); // current missing
		push_word(CMD_QUERY, 63, 0, 0, 150, 150, 150, 0, 7, 0);  // no current
		push_word(CMD_QUERY, 0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0);
		push_word(CMD_QUERY, 0, 0, 0, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0);
		push_word(CMD_UPPER, 0, 0, 0, 0, 0, 0, 0, 0, 0);         // clear the huge box
		push_word(CMD_QUERY, 0, 65535, 1, COORD_MAX, 0, 0, 0, 0, 0);
		push_word(CMD_NBR, 63, 0, 1, 0, 0, 0, 0, 0, 0);
		push_word(CMD_QUERY, 0, 7, 1, 0, 0, 0, 0, 0, 0);
		// Random: mostly well-formed boxes with neighbor links and queries.
		while (send_q.size() < ITEM_GOAL) begin
			r = $urandom_range(0, 99);
			s = $urandom_range(0, SLOTS - 1);
			if (r < 28)
				push_box(s);
			else if (r < 34)
				push_word(CMD_LOWER, s, pick_id(), 1, pick_coord(), pick_coord(),
					pick_coord(), pick_rank(), 0, 0);
			else if (r < 40) begin
				if (gen_lo_set[s])
					push_word(CMD_UPPER, s, pick_id(), $urandom_range(0, 3) != 0,
						clamp_up(gen_lo[s][0] + $urandom_range(0, 900)),
						clamp_up(gen_lo[s][1] + $urandom_range(0, 900)),
						pick_coord(), pick_rank(), $urandom_range(0, 7), 0);
			end else if (r < 58)
				push_word(CMD_NBR, s, pick_id(), $urandom_range(0, 9) != 0,
					pick_coord(), pick_coord(), pick_coord(), pick_rank(),
					$urandom_range(0, NBRS - 1), 0);
			else
				push_word(CMD_QUERY, s, pick_id(), $urandom_range(0, 4) != 0,
					pick_coord(), pick_coord(), pick_coord(), pick_rank(),
					$urandom_range(0, 7), send_q.size() % 160 == 0);
		end
	endtask

	// Driver: hold the word while stalled, advance on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				answer_q.insert(answer_q.size(), resolve_word(drv_word));
				n_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (send_q.size() > 0
						&& !(send_q[0].hold && answer_q.size() > 0)
						&& !((n_sent < 250 || n_sent > 420) && $urandom_range(0, 99) < 26)) begin
					drv_word = send_q.pop_front();
					cmd <= drv_word.cmd;
					slot <= drv_word.slot;
					area_id <= drv_word.id;
					present <= drv_word.present;
					x <= drv_word.x;
					y <= drv_word.y;
					z <= drv_word.z;
					priority_req <= drv_word.prio;
					neighbor_index <= drv_word.nidx;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, check each result word against the oldest answer.
	always @(posedge clk or negedge arst_n) begin
		answer_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			cycles++;
			if (cycles > CYC_LIMIT) begin
				$display("%0t: timeout after %0d cycles", $time, cycles);
				$display("end of test: mismatches");
				$finish;
			end
			out_stall <= (n_recv < 200 || n_recv > 380) && $urandom_range(0, 99) < 26;
			if (out_valid && !out_stall) begin
				n_recv++;
				if (answer_q.size() == 0) begin
					n_err++;
					$display("%0t: unexpected result word acc=%0b fnd=%0b id=%0d",
						$time, accepted, found, result_id);
				end else begin
					e = answer_q.pop_front();
					if (accepted !== e.acc) begin
						n_err++;
						$display("%0t: accepted expected %0b actual %0b", $time, e.acc, accepted);
					end
					if (found !== e.fnd) begin
						n_err++;
						$display("%0t: found expected %0b actual %0b", $time, e.fnd, found);
					end
					if (result_id !== e.rid) begin
						n_err++;
						$display("%0t: result_id expected %0d actual %0d",
							$time, e.rid, result_id);
					end
					if (e.fnd)
						n_found++;
					else if (!e.acc)
						n_missed++;
				end
			end
		end
	end

	initial begin
		build_stimulus();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (send_q.size() == 0);
		@(posedge clk);
		while (in_valid || answer_q.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("Checked %0d result words for %0d words sent.", n_recv, n_sent);
		$display("Queries with a hit: %0d; rejects or empty queries: %0d.", n_found, n_missed);
		if (n_err == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
